>>> hdl/tracker_pose_packet_builder_core_defines.svh
// Assertion macros shared by the packet builder RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef TRACKER_POSE_PACKET_BUILDER_CORE_DEFINES_SVH
`define TRACKER_POSE_PACKET_BUILDER_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset
`define TPPB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle
`define TPPB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/tppb_pkg.sv
// Shared types and constants for the tracker pose packet builder.
// No dependencies; used by every module of the block.
package tppb_pkg;

    // Channel and packet geometry
    localparam int IN_W       = 136;
    localparam int PKT_BYTES  = 16;
    localparam int PKT_W      = PKT_BYTES * 8;
    localparam int POS_W      = $clog2(PKT_BYTES);
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Fixed7 conversion: mg * 5021 / 4000, done as (mg * 5021 >> 5) / 125
    localparam int FIX7_MUL    = 5021;
    localparam int FIX7_SHIFT  = 5;
    localparam int FIX7_DIV    = 125;
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_125   = (1 << RECIP_SHIFT) / FIX7_DIV;

    // Smallest-three quaternion code
    localparam int QS_SHIFT  = 6;
    localparam int QS_MAX    = 511;
    localparam int QS_OFFSET = 512;

    // Packet bytes
    localparam logic [7:0] TYPE_FULL = 8'h01;
    localparam logic [7:0] TYPE_COMP = 8'h02;
    localparam logic [7:0] BATT_FLAG = 8'h80;
    localparam logic [7:0] BATT_MAX  = 8'd100;

    typedef enum logic {
        OP_FULL = 1'b0,
        OP_COMP = 1'b1
    } t_op;

    // One finished packet moving into or out of the queue
    typedef struct packed {
        logic             valid;
        logic [PKT_W-1:0] bytes;
    } t_pkt_req;

endpackage

>>> hdl/tppb_front.sv
// Front end: accepts samples and builds the 16-byte packet in three stages.
// Depends on tppb_pkg; feeds tppb_fifo.
module tppb_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_op,
    input  logic [tppb_pkg::IN_W-1:0]    i_data,
    input  logic                         i_full,
    output tppb_pkg::t_pkt_req           o_push
);

    // Magnitude of a signed 16-bit value, 32768 included
    function automatic logic [16:0] f_mag(input logic [15:0] v);
        logic [16:0] ext;
        ext = {v[15], v};
        return v[15] ? 17'(~ext + 17'd1) : ext;
    endfunction

    // Scale one component to a 10-bit offset field
    function automatic logic [9:0] f_field(input logic [15:0] q, input logic neg);
        logic signed [16:0] v;
        logic signed [16:0] s;
        v = $signed({q[15], q});
        if (neg) begin
            v = -v;
        end
        if (v[16]) begin
            s = (v + 17'sd63) >>> tppb_pkg::QS_SHIFT;
        end else begin
            s = v >>> tppb_pkg::QS_SHIFT;
        end
        if (s > 17'(tppb_pkg::QS_MAX)) begin
            s = 17'(tppb_pkg::QS_MAX);
        end
        return 10'(s + 17'(tppb_pkg::QS_OFFSET));
    endfunction

    // Correct the quotient estimate, apply sign and saturate to int16
    function automatic logic [15:0] f_fix7(input logic [22:0] b, input logic [16:0] qe,
                                           input logic neg);
        logic [23:0] prodq;
        logic [23:0] rem;
        logic [16:0] q;
        prodq = 24'(qe) * 24'(tppb_pkg::FIX7_DIV);
        rem   = 24'(b) - prodq;
        q     = (rem >= 24'(tppb_pkg::FIX7_DIV)) ? 17'(qe + 17'd1) : qe;
        if (!neg) begin
            return (q > 17'd32767) ? 16'h7FFF : q[15:0];
        end
        return (q > 17'd32768) ? 16'h8000 : 16'(17'd0 - q);
    endfunction

    logic        r_v1, r_v2, r_v3;
    logic        w_en;

    // Stage 1 registers
    logic        r_op1;
    logic [7:0]  r_id1, r_batt1, r_rssi1;
    logic [15:0] r_q1 [4];
    logic [15:0] r_a1 [3];
    logic [1:0]  r_big1;
    logic [22:0] r_b1 [3];
    logic        r_neg1 [3];

    // Stage 2 registers
    logic        r_op2;
    logic [7:0]  r_id2, r_batt2, r_rssi2;
    logic [15:0] r_q2 [4];
    logic [31:0] r_code2;
    logic [22:0] r_b2 [3];
    logic [16:0] r_qe2 [3];
    logic        r_neg2 [3];

    // Stage 3 register
    logic [tppb_pkg::PKT_W-1:0] r_pkt3;

    logic [15:0] w_q [4];
    logic [15:0] w_a [3];
    logic [16:0] w_m [4];
    logic [1:0]  n_big;
    logic [16:0] w_bm;
    logic [29:0] w_prod1 [3];
    logic [46:0] w_prod2 [3];
    logic [9:0]  w_f [4];
    logic        w_qneg;
    logic [31:0] n_code;
    logic [15:0] w_fx [3];
    logic [7:0]  w_batt;
    logic [tppb_pkg::PKT_W-1:0] n_pkt;

    // Advance all stages together unless the last one is blocked
    assign w_en    = !(r_v3 && i_full);
    assign o_ready = w_en;

    // Unpack sample fields
    assign w_q[0] = i_data[23:8];
    assign w_q[1] = i_data[39:24];
    assign w_q[2] = i_data[55:40];
    assign w_q[3] = i_data[71:56];
    assign w_a[0] = i_data[87:72];
    assign w_a[1] = i_data[103:88];
    assign w_a[2] = i_data[119:104];

    // Stage 1: find largest component, first accel multiply
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_m[i] = f_mag(w_q[i]);
        end
        n_big = 2'd0;
        w_bm  = w_m[0];
        for (int i = 1; i < 4; i++) begin
            if (w_m[i] > w_bm) begin
                w_bm  = w_m[i];
                n_big = 2'(i);
            end
        end
        for (int i = 0; i < 3; i++) begin
            w_prod1[i] = 30'(f_mag(w_a[i])) * 30'(tppb_pkg::FIX7_MUL);
        end
    end

    // Stage 2: quotient estimate, smallest-three code
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_prod2[i] = 47'(r_b1[i]) * 47'(tppb_pkg::RECIP_125);
        end
        w_qneg = r_q1[r_big1][15];
        for (int i = 0; i < 4; i++) begin
            w_f[i] = f_field(r_q1[i], w_qneg);
        end
        unique case (r_big1)
            2'd0:    n_code = {r_big1, w_f[1], w_f[2], w_f[3]};
            2'd1:    n_code = {r_big1, w_f[0], w_f[2], w_f[3]};
            2'd2:    n_code = {r_big1, w_f[0], w_f[1], w_f[3]};
            default: n_code = {r_big1, w_f[0], w_f[1], w_f[2]};
        endcase
    end

    // Stage 3: finish accel and lay out the packet
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_fx[i] = f_fix7(r_b2[i], r_qe2[i], r_neg2[i]);
        end
        w_batt = (r_batt2 > tppb_pkg::BATT_MAX) ? tppb_pkg::BATT_MAX : r_batt2;
        unique case (tppb_pkg::t_op'(r_op2))
            tppb_pkg::OP_FULL: n_pkt = {w_fx[2], w_fx[1], w_fx[0], r_q2[0], r_q2[3],
                                        r_q2[2], r_q2[1], r_id2, tppb_pkg::TYPE_FULL};
            tppb_pkg::OP_COMP: n_pkt = {r_rssi2, w_fx[2], w_fx[1], w_fx[0], r_code2,
                                        8'h00, 8'h00, tppb_pkg::BATT_FLAG | w_batt,
                                        r_id2, tppb_pkg::TYPE_COMP};
            default:           n_pkt = '0;
        endcase
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_op1   <= i_op;
            r_id1   <= i_data[7:0];
            r_batt1 <= i_data[127:120];
            r_rssi1 <= i_data[135:128];
            r_big1  <= n_big;
            for (int i = 0; i < 4; i++) begin
                r_q1[i] <= w_q[i];
                r_q2[i] <= r_q1[i];
            end
            for (int i = 0; i < 3; i++) begin
                r_a1[i]   <= w_a[i];
                r_b1[i]   <= w_prod1[i][27:tppb_pkg::FIX7_SHIFT];
                r_neg1[i] <= w_a[i][15];
                r_b2[i]   <= r_b1[i];
                r_qe2[i]  <= w_prod2[i][46:tppb_pkg::RECIP_SHIFT];
                r_neg2[i] <= r_neg1[i] && (r_a1[i] != 16'd0);
            end
            r_op2   <= r_op1;
            r_id2   <= r_id1;
            r_batt2 <= r_batt1;
            r_rssi2 <= r_rssi1;
            r_code2 <= n_code;
            r_pkt3  <= n_pkt;
        end
    end

    assign o_push.valid = r_v3;
    assign o_push.bytes = r_pkt3;

endmodule

>>> hdl/tppb_fifo.sv
// Two-entry packet queue between the front end and the byte serializer.
// Depends on tppb_pkg and the shared assertion macros.
`include "tracker_pose_packet_builder_core_defines.svh"

module tppb_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tppb_pkg::t_pkt_req i_push,
    output logic               o_full,
    output tppb_pkg::t_pkt_req o_head,
    input  logic               i_pop
);

    logic [tppb_pkg::PKT_W-1:0]   r_mem [tppb_pkg::FIFO_DEPTH];
    logic [tppb_pkg::FIFO_AW-1:0] r_wp, r_rp;
    logic [tppb_pkg::FIFO_CW-1:0] r_cnt;
    logic                         w_wr, w_rd;

    assign o_full       = (r_cnt == tppb_pkg::FIFO_CW'(tppb_pkg::FIFO_DEPTH));
    assign w_wr         = i_push.valid && !o_full;
    assign w_rd         = i_pop && (r_cnt != '0);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.bytes = r_mem[r_rp];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + tppb_pkg::FIFO_CW'(w_wr) - tppb_pkg::FIFO_CW'(w_rd);
        end
    end

    // Store pushed packet
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_push.bytes;
        end
    end

    `TPPB_ASSERT(a_fifo_no_underflow, !i_pop || (r_cnt != '0), "pop from empty packet queue")
    `TPPB_ASSERT(a_fifo_bound, r_cnt <= tppb_pkg::FIFO_CW'(tppb_pkg::FIFO_DEPTH), "queue count overrun")

endmodule

>>> hdl/tppb_back.sv
// Back end: streams the head out one byte per ready cycle, with position and last.
// Depends on tppb_pkg and the shared assertion macros.
`include "tracker_pose_packet_builder_core_defines.svh"

module tppb_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tppb_pkg::t_pkt_req         i_head,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [7:0]                 o_byte,
    output logic [tppb_pkg::POS_W-1:0] o_pos,
    output logic                       o_last
);

    logic                       r_ov;
    logic [7:0]                 r_byte;
    logic [tppb_pkg::POS_W-1:0] r_pos;
    logic                       r_last;
    logic [tppb_pkg::POS_W-1:0] r_idx;
    logic                       w_load;
    logic                       w_idx_last;

    assign w_load     = i_head.valid && (!r_ov || i_ready);
    assign w_idx_last = (r_idx == tppb_pkg::POS_W'(tppb_pkg::PKT_BYTES - 1));
    assign o_pop      = w_load && w_idx_last;

    // Output valid and byte index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_idx <= '0;
        end else begin
            if (w_load) begin
                r_ov  <= 1'b1;
                r_idx <= r_idx + 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_head.bytes[{r_idx, 3'b000} +: 8];
            r_pos  <= r_idx;
            r_last <= w_idx_last;
        end
    end

    assign o_valid = r_ov;
    assign o_byte  = r_byte;
    assign o_pos   = r_pos;
    assign o_last  = r_last;

    `TPPB_ASSERT_NEXT(a_back_no_gap, r_ov && i_ready && !r_last, r_ov && (r_pos == $past(r_pos) + 1'b1), "gap or skip inside a packet")
    `TPPB_ASSERT_NEXT(a_back_restart, r_ov && i_ready && r_last, !r_ov || (r_pos == '0), "packet does not start at byte zero")

endmodule

>>> hdl/tracker_pose_packet_builder_core.sv
// Top level of the tracker pose packet builder.
// Depends on tppb_pkg, tppb_front, tppb_fifo and tppb_back.
//
// Usage:
//   Slave channel s_axis_* takes one tracker sample per request; tuser selects
//   the packet kind (0 full precision, 1 compressed). Master channel m_axis_*
//   returns the 16-byte packet one byte per request, byte position in tdata
//   and tlast on byte fifteen.
//   When the block is empty, a sample passes the three build stages, the queue
//   and the output register before its first byte is offered.
//   Throughput is set by the one-byte output port; the build pipeline takes a
//   sample every cycle while its last stage is not blocked, and a two-entry
//   packet queue lets it run ahead of the serializer.
//   Reset (i_rst_n low, synchronous) empties the pipeline, the queue and the
//   output register; nothing is emitted afterwards until a new sample.
//   When m_axis_tready is low the current byte holds; the queue then fills
//   and s_axis_tready drops once the last build stage cannot drain.
module tracker_pose_packet_builder_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [7:0] tracker_number, [23:8] quat_w_in, [39:24] quat_x_in,
    // [55:40] quat_y_in, [71:56] quat_z_in, [87:72] accel_x_mg,
    // [103:88] accel_y_mg, [119:104] accel_z_mg, [127:120] battery_percent,
    // [135:128] signal_strength
    input  logic [135:0] s_axis_tdata,
    // [0] operation
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] packet_byte, [11:8] byte_position, [15:12] zero
    output logic [15:0]  m_axis_tdata,
    // last_byte
    output logic         m_axis_tlast
);

    tppb_pkg::t_pkt_req         w_push;
    tppb_pkg::t_pkt_req         w_head;
    logic                       w_full;
    logic                       w_pop;
    logic [7:0]                 w_byte;
    logic [tppb_pkg::POS_W-1:0] w_pos;

    tppb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_op    (s_axis_tuser),
        .i_data  (s_axis_tdata),
        .i_full  (w_full),
        .o_push  (w_push)
    );

    tppb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    tppb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_byte  (w_byte),
        .o_pos   (w_pos),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, w_pos, w_byte};

endmodule
